// ===== rtl/poly1305_mac_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Poly1305 MAC unit
// ---------------------------------------------------------------------------
`ifndef POLY1305_MAC_UNIT_MACROS_SVH
`define POLY1305_MAC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define P13_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define P13_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
        else $error("assertion failed");
`else
`define P13_ASSERT_IMPL(label, clk, rst_n, prop)
`define P13_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/p1305_pkg.sv =====
// ---------------------------------------------------------------------------
// p1305_pkg
// Types and constants for the Poly1305 MAC unit.
// ---------------------------------------------------------------------------
package p1305_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_R_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_S_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_S_HIGH = 2'd3;
    localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_FIN,
        ST_OUT
    } state_t;
endpackage

// ===== rtl/poly1305_mac_unit.sv =====
// ---------------------------------------------------------------------------
// poly1305_mac_unit
// Poly1305 one-time authenticator, one 16-byte block per transaction.
//
//  channel | dir | tdata bits                              | tuser | tlast
//  s_      | in  | block_low, block_high, byte_count (136) | -     | last
//  m_      | out | tag_low, tag_high (128)                 | -     | -
//
// A block runs through the states MUL, RED and FIN before the next accept: steps of one
// shared 27x29 limb multiply (h limb by r limb, wrapped terms times 5), the
// folds of the bits above 130, one final compare, then a return to idle.
// A last block adds the s add in the compare cycle; the tag then sits in m_
// until taken, and s_tready stays low meanwhile.
// Reset is synchronous.
// ---------------------------------------------------------------------------
`include "poly1305_mac_unit_macros.svh"
module poly1305_mac_unit
    import p1305_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    // block_low[63:0], block_high[127:64], byte_count[132:128], zero pad
    input  logic [135:0]   s_tdata,
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    // tag_low[63:0], tag_high[127:64]
    output logic [127:0]   m_tdata
);
    localparam logic [129:0] P = {2'b11, {126{1'b1}}, 2'b11} - 130'd4; // 2^130-5

    logic [127:0] r_key_reg, s_key_reg;
    logic [129:0] acc_reg, acc_next;
    logic [130:0] h_reg, h_next;       // accumulator + block
    logic [166:0] prod_reg, prod_next; // limb product sum, below 2^165
    logic [2:0]   limb_reg, limb_next; // h limb
    logic [2:0]   col_reg, col_next;   // product column
    logic         last_reg, last_next;
    logic [127:0] tag_reg, tag_next;
    state_t       state_reg, state_next;

    logic [127:0] r_cl;
    logic [26:0]  h_limb;
    logic [2:0]   r_idx;
    logic [25:0]  r_sel;
    logic [28:0]  r_mul;
    logic [55:0]  mul_term;
    logic [166:0] term_sh;
    logic [130:0] padded;
    logic [4:0]   n_sat;
    logic [127:0] msk;
    logic [130:0] red1, red2;
    logic [131:0] diff;
    logic [129:0] acc_fin;

    assign r_cl = r_key_reg & R_CLAMP;

    // byte count handling and pad bit
    always_comb begin
        n_sat = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
        msk   = (n_sat[4]) ? {128{1'b1}} : ((128'd1 << {n_sat[3:0], 3'b000}) - 128'd1);
        padded = {3'b000, s_tdata[127:0] & msk};
        padded = padded | (131'd1 << {n_sat, 3'b000});
    end

    // Column col gets h[limb] * r[col-limb]; wrapped terms land on 2^130
    // and fold back in times 5.
    always_comb begin
        case (limb_reg)
            3'd0: h_limb = {1'b0, h_reg[25:0]};
            3'd1: h_limb = {1'b0, h_reg[51:26]};
            3'd2: h_limb = {1'b0, h_reg[77:52]};
            3'd3: h_limb = {1'b0, h_reg[103:78]};
            default: h_limb = h_reg[130:104];
        endcase
        r_idx = (limb_reg <= col_reg) ? (col_reg - limb_reg) : (col_reg + 3'd5 - limb_reg);
        case (r_idx)
            3'd0: r_sel = r_cl[25:0];
            3'd1: r_sel = r_cl[51:26];
            3'd2: r_sel = r_cl[77:52];
            3'd3: r_sel = r_cl[103:78];
            default: r_sel = {2'b00, r_cl[127:104]};
        endcase
        r_mul = (limb_reg <= col_reg) ? {3'd0, r_sel}
                                      : ({3'd0, r_sel} << 2) + {3'd0, r_sel};
        mul_term = {29'd0, h_limb} * {27'd0, r_mul};
        case (col_reg)
            3'd0: term_sh = {111'd0, mul_term};
            3'd1: term_sh = {85'd0, mul_term, 26'd0};
            3'd2: term_sh = {59'd0, mul_term, 52'd0};
            3'd3: term_sh = {33'd0, mul_term, 78'd0};
            default: term_sh = {7'd0, mul_term, 104'd0};
        endcase
    end

    always_comb begin
        red1 = {1'b0, prod_reg[129:0]} + {92'd0, prod_reg[166:130], 2'b00}
               + {94'd0, prod_reg[166:130]};
        red2 = {1'b0, red1[129:0]} + {128'd0, red1[130], 1'b0, red1[130]};
        diff = {1'b0, prod_reg[130:0]} - {2'b00, P};
        acc_fin = diff[131] ? prod_reg[129:0] : diff[129:0];
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        h_next     = h_reg;
        prod_next  = prod_reg;
        limb_next  = limb_reg;
        col_next   = col_reg;
        last_next  = last_reg;
        tag_next   = tag_reg;
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                h_next     = padded + {1'b0, acc_reg};
                prod_next  = '0;
                limb_next  = '0;
                col_next   = '0;
                last_next  = s_tlast;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next = prod_reg + term_sh;
                if (limb_reg == 3'd4) begin
                    limb_next = '0;
                    if (col_reg == 3'd4) state_next = ST_RED;
                    else col_next = col_reg + 3'd1;
                end else begin
                    limb_next = limb_reg + 3'd1;
                end
            end
            ST_RED: begin
                // two folds leave a value below 2^130+5
                prod_next  = {36'd0, red2};
                state_next = ST_FIN;
            end
            ST_FIN: begin
                acc_next = acc_fin;
                if (last_reg) begin
                    tag_next   = acc_fin[127:0] + s_key_reg;
                    acc_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            r_key_reg <= '0;
            s_key_reg <= '0;
            limb_reg  <= '0;
            col_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            limb_reg  <= limb_next;
            col_reg   <= col_next;
            last_reg  <= last_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_R_LOW:  r_key_reg[63:0]   <= cfg_data;
                    REG_R_HIGH: r_key_reg[127:64] <= cfg_data;
                    REG_S_LOW:  s_key_reg[63:0]   <= cfg_data;
                    REG_S_HIGH: s_key_reg[127:64] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        prod_reg <= prod_next;
        tag_reg  <= tag_next;
    end

    `P13_ASSERT_IMPL(a_ready_out_excl, aclk, aresetn, !(s_tready && m_tvalid))
    `P13_ASSERT_NEXT(a_acc_canon, aclk, aresetn, (state_reg == ST_FIN), (acc_reg < P))
    `P13_ASSERT_NEXT(a_mul_len, aclk, aresetn,
        (state_reg == ST_MUL && limb_reg == 3'd4 && col_reg == 3'd4), (state_reg == ST_RED))
endmodule
